### design/hstd_pkg.sv
package hstd_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  localparam logic [SampleW-1:0] FallbackLevel = SampleW'(200);

  typedef enum logic [1:0] {
    RegUpRest   = 2'd0,
    RegDownRest = 2'd1,
    RegUpTrig   = 2'd2,
    RegDownTrig = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0] up_sample;
    logic [SampleW-1:0] down_sample;
    logic               host_linked;
  } in_item_t;

  typedef struct packed {
    logic up_active;
    logic down_active;
    logic up_press_pulse;
    logic down_press_pulse;
    logic report_due;
    logic mechanical_fallback;
  } out_item_t;

  // per-channel settings; the release bound is worked out when the level is written
  typedef struct packed {
    logic [SampleW-1:0] rest;
    logic [SampleW-1:0] trig;
    logic [SampleW-1:0] hold_bound;
    logic               hold_all;
  } chan_cfg_t;

endpackage

### design/hstd_if.sv
interface hstd_in_if;
  import hstd_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface hstd_out_if;
  import hstd_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### design/hall_strum_threshold_detector.sv
// Hall strum threshold detector: each beat on in_i carries one up and one down hall
// sample; each channel is EMA-smoothed, its deviation from the rest offset is debounced
// against the trigger level with hysteresis, and one result beat per input beat appears
// on out_o at one beat per clock while out_o keeps up, via the input register, then the
// single-pass channel update into the result register. While a finished result waits
// the input register can still take one beat; with both full the input stalls until out_o
// takes the result. Items with host_linked low, and all items once the fallback has
// latched, leave the state untouched. Rest offsets and trigger levels sit on the APB port
// at byte addresses 0, 4, 8 and 12; write them only while no beat is in flight.
module hall_strum_threshold_detector #(
  parameter int unsigned CONFIRM_COUNT = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hstd_pkg::AddrW-1:0] paddr,
  input  logic [hstd_pkg::DataW-1:0] pwdata,
  output logic [hstd_pkg::DataW-1:0] prdata,
  output logic                       pready,
  hstd_in_if.sink                    in_i,
  hstd_out_if.source                 out_o
);
  import hstd_pkg::*;

  chan_cfg_t up_cfg, down_cfg;
  logic      s1_valid_q, s1_valid_d, res_valid_q, res_valid_d;
  in_item_t  s1_q;
  out_item_t res_q, res_d;
  logic      s1_adv, in_acc, step;
  logic      live, below, upd;
  logic      fb_q, fb_d;
  logic      up_nd, up_q, dn_nd, dn_q;

  hstd_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .up_cfg_o(up_cfg), .down_cfg_o(down_cfg)
  );

  hstd_chan #(.CONFIRM_COUNT(CONFIRM_COUNT)) u_up (
    .clk_i, .rst_ni, .step_i(upd), .raw_i(s1_q.up_sample), .cfg_i(up_cfg),
    .act_d_o(up_nd), .act_q_o(up_q)
  );

  hstd_chan #(.CONFIRM_COUNT(CONFIRM_COUNT)) u_down (
    .clk_i, .rst_ni, .step_i(upd), .raw_i(s1_q.down_sample), .cfg_i(down_cfg),
    .act_d_o(dn_nd), .act_q_o(dn_q)
  );

  assign s1_adv     = !res_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;
  assign step       = s1_valid_q && s1_adv;

  assign live  = s1_q.host_linked && !fb_q;
  assign below = (s1_q.up_sample < FallbackLevel) || (s1_q.down_sample < FallbackLevel);
  assign upd   = step && live && !below;
  assign fb_d  = fb_q || (step && live && below);

  always_comb begin
    s1_valid_d  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    res_valid_d = s1_adv ? s1_valid_q : res_valid_q;
    if (live && !below) begin
      res_d.up_active        = up_nd;
      res_d.down_active      = dn_nd;
      res_d.up_press_pulse   = up_nd && !up_q;
      res_d.down_press_pulse = dn_nd && !dn_q;
      res_d.report_due       = (up_nd != up_q) || (dn_nd != dn_q);
    end else begin
      res_d.up_active        = up_q;
      res_d.down_active      = dn_q;
      res_d.up_press_pulse   = 1'b0;
      res_d.down_press_pulse = 1'b0;
      res_d.report_due       = 1'b0;
    end
    res_d.mechanical_fallback = fb_q || (live && below);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      fb_q        <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
      fb_q        <= fb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_i.payload;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid   = res_valid_q;
  assign out_o.payload = res_q;

  a_fb_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fb_q |=> fb_q)
    else $error("fallback flag cleared");

  a_no_update_after_fb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fb_q |-> !upd)
    else $error("channel updated after fallback");

  a_pulse_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.payload.up_press_pulse || out_o.payload.down_press_pulse))
      |-> out_o.payload.report_due)
    else $error("press pulse without report");

endmodule

### design/hstd_cfg.sv
module hstd_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hstd_pkg::AddrW-1:0] paddr,
  input  logic [hstd_pkg::DataW-1:0] pwdata,
  output logic [hstd_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output hstd_pkg::chan_cfg_t        up_cfg_o,
  output hstd_pkg::chan_cfg_t        down_cfg_o
);
  import hstd_pkg::*;

  localparam int unsigned HystMin = 40;
  // floor(t*15/100) == floor(floor(3t/4)/5); /5 by reciprocal 3277/2^14, exact below 2^14
  localparam int unsigned RecipFive  = 3277;
  localparam int unsigned RecipShift = 14;
  localparam int unsigned ProdW      = RecipShift + SampleW;

  typedef struct packed {
    logic [SampleW-1:0] bound;
    logic               all;
  } hold_t;

  function automatic hold_t hold_of(input logic [SampleW-1:0] t);
    logic [SampleW+1:0] t3;
    logic [SampleW-1:0] q4;
    logic [ProdW-1:0]   prod;
    logic [SampleW-1:0] h;
    hold_t              r;
    t3   = {2'b00, t} + {1'b0, t, 1'b0};
    q4   = t3[SampleW+1:2];
    prod = {{RecipShift{1'b0}}, q4} * ProdW'(RecipFive);
    h    = prod[ProdW-1:RecipShift];
    if (h < SampleW'(HystMin)) begin
      h = SampleW'(HystMin);
    end
    r.all   = h > t;
    r.bound = t - h;
    return r;
  endfunction

  localparam logic [SampleW-1:0] RestReset = SampleW'(2048);
  localparam logic [SampleW-1:0] TrigReset = SampleW'(400);
  localparam hold_t              HoldReset = '{bound: SampleW'(340), all: 1'b0};

  logic [SampleW-1:0] up_rest_q, down_rest_q, up_trig_q, down_trig_q;
  hold_t              up_hold_q, down_hold_q;
  logic               wr_en;
  reg_idx_e           idx;
  logic [SampleW-1:0] wval;
  hold_t              whold;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wval   = pwdata[SampleW-1:0];
  assign whold  = hold_of(wval);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_rest_q   <= RestReset;
      down_rest_q <= RestReset;
      up_trig_q   <= TrigReset;
      down_trig_q <= TrigReset;
      up_hold_q   <= HoldReset;
      down_hold_q <= HoldReset;
    end else if (wr_en) begin
      unique case (idx)
        RegUpRest:   up_rest_q <= wval;
        RegDownRest: down_rest_q <= wval;
        RegUpTrig: begin
          up_trig_q <= wval;
          up_hold_q <= whold;
        end
        RegDownTrig: begin
          down_trig_q <= wval;
          down_hold_q <= whold;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      RegUpRest:   prdata = DataW'(up_rest_q);
      RegDownRest: prdata = DataW'(down_rest_q);
      RegUpTrig:   prdata = DataW'(up_trig_q);
      RegDownTrig: prdata = DataW'(down_trig_q);
      default:     prdata = '0;
    endcase
  end

  assign up_cfg_o   = '{rest: up_rest_q, trig: up_trig_q,
                        hold_bound: up_hold_q.bound, hold_all: up_hold_q.all};
  assign down_cfg_o = '{rest: down_rest_q, trig: down_trig_q,
                        hold_bound: down_hold_q.bound, hold_all: down_hold_q.all};

endmodule

### design/hstd_chan.sv
module hstd_chan #(
  parameter int unsigned CONFIRM_COUNT = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [hstd_pkg::SampleW-1:0] raw_i,
  input  hstd_pkg::chan_cfg_t          cfg_i,
  output logic                         act_d_o,
  output logic                         act_q_o
);
  import hstd_pkg::*;

  localparam int unsigned CntW = $clog2(CONFIRM_COUNT + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(CONFIRM_COUNT);

  logic [SampleW-1:0] sm_q, sm_d, sm_base, dev;
  logic [SampleW+1:0] ema_sum;
  logic               primed_q;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               act_q;
  logic               above, hold;

  always_comb begin
    sm_base = primed_q ? sm_q : raw_i;
    // 3*f + raw, then /4
    ema_sum = {1'b0, sm_base, 1'b0} + {2'b00, sm_base} + {2'b00, raw_i};
    sm_d    = ema_sum[SampleW+1:2];
    dev     = (sm_d >= cfg_i.rest) ? sm_d - cfg_i.rest : cfg_i.rest - sm_d;
    above   = dev > cfg_i.trig;
    hold    = cfg_i.hold_all || (dev > cfg_i.hold_bound);
    priority if (above) begin
      cnt_d = (cnt_q < CntMax) ? cnt_q + CntW'(1) : cnt_q;
    end else if (hold) begin
      cnt_d = (cnt_q == '0) ? CntW'(1) : cnt_q;
    end else begin
      cnt_d = '0;
    end
    act_d_o = (cnt_d >= CntMax) || (act_q && hold);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_q     <= '0;
      primed_q <= 1'b0;
      cnt_q    <= '0;
      act_q    <= 1'b0;
    end else if (step_i) begin
      sm_q     <= sm_d;
      primed_q <= 1'b1;
      cnt_q    <= cnt_d;
      act_q    <= act_d_o;
    end
  end

  assign act_q_o = act_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("confirm count beyond limit");

endmodule
